FILE: hw/rtl/gpc_pkg.sv
// ----------------------------------------------------------------------------
// gpc_pkg
// Shared types and constants of the Goldbach partition counter: field
// widths, command and status codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package gpc_pkg;

	// Field widths of the stream payloads and the config register
	localparam int NUM_W  = 18;
	localparam int CNT_W  = 16;
	localparam int STS_W  = 2;
	localparam int CFG_W  = 18;
	localparam int DATA_W = 24;
	localparam int APB_W  = 32;
	localparam int ADDR_W = 3;

	// Default largest sieve limit
	localparam int DEF_MAX_LIMIT = 131072;

	// Reset value of the sieve_limit register
	localparam logic [CFG_W-1:0] SIEVE_LIMIT_RST = CFG_W'(100000);

	// Smallest sieve limit a build uses
	localparam int MIN_LIMIT = 4;

	// Saturation value of the count field
	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	// Command codes (tuser)
	localparam logic CMD_BUILD = 1'b0;
	localparam logic CMD_COUNT = 1'b1;

	// Status codes
	localparam logic [STS_W-1:0] STS_OK        = 2'd0;
	localparam logic [STS_W-1:0] STS_ABOVE     = 2'd1;
	localparam logic [STS_W-1:0] STS_NOT_BUILT = 2'd2;

	// Register index of sieve_limit (paddr[2])
	localparam logic REG_SIEVE_LIMIT = 1'b0;

	// Sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_INIT,
		S_SV_RD,
		S_SV_CHK,
		S_CROSS,
		S_TALLY,
		S_COUNT,
		S_FLUSH,
		S_DONE
	} gpc_state_t;

endpackage

FILE: hw/rtl/gpc_ram.sv
// ----------------------------------------------------------------------------
// gpc_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module gpc_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

FILE: hw/rtl/goldbach_partition_counter_core.sv
// ----------------------------------------------------------------------------
// goldbach_partition_counter_core
// Odd-only sieve of Eratosthenes and Goldbach partition counter behind a
// stream input, a stream output and an APB register port.
// ----------------------------------------------------------------------------
// One item is worked at a time; s_tready is high only while the sequencer is
// idle, and a finished result waits in the output register while the next
// item is taken. A build command (tuser 0) fills the bitmap, crosses out the
// odd multiples of each odd prime candidate up to sqrt(lim), starting at its
// square, and then counts the primes, where lim is sieve_limit clamped to
// [4, MAX_LIMIT]. A count command (tuser 1) walks the odd p up to x/2, one
// candidate per cycle through the two read ports of the bitmap RAM; error
// cases and odd x go straight to the result. The bitmap is a 1-bit RAM of
// MAX_LIMIT/2+1 entries, written by a build only; a count before any build
// returns status 2, and x above the built limit returns status 1. Counts
// saturate at 65535.
// ----------------------------------------------------------------------------
module goldbach_partition_counter_core
	import gpc_pkg::*;
#(
	parameter int MAX_LIMIT = DEF_MAX_LIMIT
) (
	input  logic              clk,
	input  logic              arst_n,
	// Input stream
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,   // [17:0] number
	input  logic              s_tuser,   // [0] cmd
	// Output stream
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,   // [15:0] count, [17:16] status
	// Config port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [APB_W-1:0]  pwdata,
	output logic [APB_W-1:0]  prdata,
	output logic              pready
);

	// Widths derived from the largest limit
	localparam int LIM_W = $clog2(MAX_LIMIT + 1);
	localparam int VW    = (LIM_W > NUM_W) ? LIM_W : NUM_W;
	localparam int WW    = VW + 1;
	localparam int DEPTH = MAX_LIMIT / 2 + 1;
	localparam int AW    = $clog2(DEPTH);

	localparam logic [WW-1:0] MAX_W = WW'(MAX_LIMIT);
	localparam logic [WW-1:0] MIN_W = WW'(MIN_LIMIT);
	localparam logic [WW-1:0] ONE_W = WW'(1);
	localparam logic [WW-1:0] TWO_W = WW'(2);
	localparam logic [WW-1:0] THR_W = WW'(3);
	localparam logic [WW-1:0] FOR_W = WW'(4);
	localparam logic [WW-1:0] NIN_W = WW'(9);

	gpc_state_t state_q, state_d;

	logic [CFG_W-1:0] sieve_limit_q;
	logic             map_valid_q;
	logic [VW-1:0]    built_limit_q;
	logic [WW-1:0]    lim_q;
	logic [WW-1:0]    w_q;
	logic [WW-1:0]    st_q;
	logic [WW-1:0]    q_q;
	logic [WW-1:0]    i_q;
	logic [WW-1:0]    sq_q;
	logic [CNT_W-1:0] cnt_q;
	logic [STS_W-1:0] sts_q;
	logic             is_build_q;
	logic             rv_s1;
	logic             pair_s1;
	logic             m_tvalid_q;
	logic [CNT_W-1:0] m_count_q;
	logic [STS_W-1:0] m_sts_q;

	// Shared unit and RAM controls
	logic [WW-1:0] cmp_a, cmp_b, sum;
	logic          le;
	logic          ram_we, ram_wdata, rd_en;
	logic [AW-1:0] ram_waddr, raddr_a, raddr_b;
	logic          rdata_a, rdata_b;

	logic          s_xfer, cfg_wr, out_free;
	logic [WW-1:0] sl_w, lim_clamp, xw;
	logic [WW-1:0] i_next, sq_next;

	// ------------------------------------------------------------------
	// Config port
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sieve_limit_q <= SIEVE_LIMIT_RST;
		end else if (cfg_wr && paddr[2] == REG_SIEVE_LIMIT) begin
			sieve_limit_q <= pwdata[CFG_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_SIEVE_LIMIT) begin
			prdata = APB_W'(sieve_limit_q);
		end
	end

	// ------------------------------------------------------------------
	// Input decode
	// ------------------------------------------------------------------
	assign s_xfer = s_tvalid & s_tready;
	assign xw     = WW'(s_tdata[NUM_W-1:0]);
	assign sl_w   = WW'(sieve_limit_q);

	always_comb begin
		lim_clamp = sl_w;
		if (sl_w < MIN_W) begin
			lim_clamp = MIN_W;
		end else if (sl_w > MAX_W) begin
			lim_clamp = MAX_W;
		end
	end

	// Next sieving candidate: i += 2, i*i += 4i + 4
	assign i_next  = i_q + TWO_W;
	assign sq_next = sq_q + {i_q[WW-3:0], 2'b00} + FOR_W;

	assign out_free = !m_tvalid_q || m_tready;

	// ------------------------------------------------------------------
	// Next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_xfer) begin
					if (s_tuser == CMD_BUILD) begin
						state_d = S_INIT;
					end else if (map_valid_q && xw <= WW'(built_limit_q)
						&& xw > TWO_W && !xw[0]) begin
						state_d = S_COUNT;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_INIT:   state_d = le ? S_INIT : S_SV_RD;
			S_SV_RD:  state_d = le ? S_SV_CHK : S_TALLY;
			S_SV_CHK: state_d = rdata_a ? S_CROSS : S_SV_RD;
			S_CROSS:  state_d = le ? S_CROSS : S_SV_RD;
			S_TALLY:  state_d = le ? S_TALLY : S_FLUSH;
			S_COUNT:  state_d = le ? S_COUNT : S_FLUSH;
			S_FLUSH:  state_d = S_DONE;
			S_DONE:   state_d = out_free ? S_IDLE : S_DONE;
			default:  state_d = S_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Shared compare operands
	// ------------------------------------------------------------------
	always_comb begin
		cmp_a = w_q;
		cmp_b = lim_q;
		case (state_q)
			S_SV_RD: cmp_a = sq_q;
			S_COUNT: cmp_b = q_q;
			default: begin
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Outputs: RAM controls, ready
	// ------------------------------------------------------------------
	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = 1'b0;
		rd_en     = 1'b0;
		raddr_a   = w_q[AW:1];
		raddr_b   = q_q[AW:1];
		s_tready  = 1'b0;
		case (state_q)
			S_IDLE: s_tready = 1'b1;
			S_INIT: begin
				ram_we    = le;
				ram_wdata = (w_q != ONE_W);
			end
			S_SV_RD: raddr_a = i_q[AW:1];
			S_CROSS: ram_we = le;
			S_TALLY: rd_en = le;
			S_COUNT: rd_en = le;
			default: begin
			end
		endcase
		ram_waddr = w_q[AW:1];
	end

	// Shared walker adder and bound compare
	assign sum = w_q + st_q;
	assign le  = (cmp_a <= cmp_b);

	// ------------------------------------------------------------------
	// Datapath registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		// Tally of the registered read data
		if (rv_s1 && rdata_a && (rdata_b || !pair_s1) && cnt_q != COUNT_MAX) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
		case (state_q)
			S_IDLE: begin
				if (s_xfer) begin
					is_build_q <= (s_tuser == CMD_BUILD);
					lim_q      <= lim_clamp;
					st_q       <= TWO_W;
					q_q        <= xw - THR_W;
					if (s_tuser == CMD_BUILD) begin
						w_q   <= ONE_W;
						sts_q <= STS_OK;
						cnt_q <= '0;
					end else begin
						w_q <= THR_W;
						if (!map_valid_q) begin
							sts_q <= STS_NOT_BUILT;
						end else if (xw > WW'(built_limit_q)) begin
							sts_q <= STS_ABOVE;
						end else begin
							sts_q <= STS_OK;
						end
						// x - 2 = 2 is the only even prime partner
						cnt_q <= (map_valid_q && xw == FOR_W) ? CNT_W'(1) : '0;
					end
				end
			end
			S_INIT: begin
				if (le) begin
					w_q <= sum;
				end else begin
					i_q  <= THR_W;
					sq_q <= NIN_W;
				end
			end
			S_SV_RD: begin
				if (!le) begin
					// Prime count starts at 1 for the number 2
					cnt_q <= CNT_W'(1);
					w_q   <= THR_W;
					st_q  <= TWO_W;
				end
			end
			S_SV_CHK: begin
				if (rdata_a) begin
					w_q  <= sq_q;
					st_q <= {i_q[WW-2:0], 1'b0};
				end else begin
					i_q  <= i_next;
					sq_q <= sq_next;
				end
			end
			S_CROSS: begin
				if (le) begin
					w_q <= sum;
				end else begin
					i_q  <= i_next;
					sq_q <= sq_next;
				end
			end
			S_TALLY: begin
				if (le) begin
					w_q <= sum;
				end
			end
			S_COUNT: begin
				if (le) begin
					w_q <= sum;
					q_q <= q_q - TWO_W;
				end
			end
			default: begin
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Control registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			map_valid_q   <= 1'b0;
			built_limit_q <= '0;
			rv_s1         <= 1'b0;
			pair_s1       <= 1'b0;
			m_tvalid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			rv_s1   <= rd_en;
			pair_s1 <= (state_q == S_COUNT);
			if (state_q == S_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
				if (is_build_q) begin
					map_valid_q   <= 1'b1;
					built_limit_q <= lim_q[VW-1:0];
				end
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Output payload register
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			m_count_q <= cnt_q;
			m_sts_q   <= sts_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = DATA_W'({m_sts_q, m_count_q});

	// ------------------------------------------------------------------
	// Bitmap RAM
	// ------------------------------------------------------------------
	gpc_ram #(
		.WIDTH(1),
		.DEPTH(DEPTH)
	) u_map (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (ram_wdata),
		.raddr_a(raddr_a),
		.rdata_a(rdata_a),
		.raddr_b(raddr_b),
		.rdata_b(rdata_b)
	);

`ifndef SYNTHESIS
	// Partition walk pairs two odd numbers
	a_count_odd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COUNT) |-> (w_q[0] && q_q[0]))
		else $error("count walk left odd numbers");

	// Crossing out starts at an odd square with a nonzero stride
	a_cross_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CROSS) |-> (w_q[0] && st_q != '0 && !st_q[0]))
		else $error("bad crossing-out stride");

	// A built map always has a limit within range
	a_built_lim: assert property (@(posedge clk) disable iff (!arst_n)
		map_valid_q |-> (WW'(built_limit_q) >= MIN_W && WW'(built_limit_q) <= MAX_W))
		else $error("built limit out of range");
`endif

endmodule

FILE: verif/goldbach_partition_counter_core_tb.sv
// ----------------------------------------------------------------------------
// goldbach_partition_counter_core_tb
// Self-checking bench for the sieve builder and Goldbach partition counter.
// ----------------------------------------------------------------------------
// Items go in on the input stream, the sieve limit is set over APB. A local
// odd-only sieve predicts every result and the output stream is compared
// field by field against the queue of predictions. Directed tests cover the
// not-built and above-limit errors, odd and tiny numbers and the clamped
// limits at both ends. Random phases then rebuild the sieve at random limits
// and mix counts, rebuilds and error cases, with random gaps on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module goldbach_partition_counter_core_tb;
	import gpc_pkg::*;

	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 9;
	localparam int MAX_GAP       = 13;
	localparam int END_CYCLES    = 64;
	localparam int CYCLE_LIMIT   = 6_000_000;
	localparam int MAP_DEPTH     = DEF_MAX_LIMIT / 2 + 1;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS   = 12;
	localparam int WIDE_PHASE    = 3;
	localparam int WIDE_SPAN     = 8192;
	localparam int NUM_MAX       = 2**NUM_W - 1;
	localparam logic [ADDR_W-1:0] SIEVE_LIMIT_ADDR = {REG_SIEVE_LIMIT, 2'b00};

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [STS_W-1:0] status;
	} partition_result_t;

	// DUT ports
	logic              clk = 1'b0;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata;   // [17:0] number
	logic              s_tuser;   // [0] cmd
	logic              m_tvalid;
	logic              m_tready;
	logic [DATA_W-1:0] m_tdata;   // [15:0] count, [17:16] status
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [APB_W-1:0]  pwdata;
	logic [APB_W-1:0]  prdata;
	logic              pready;

	// Predictor state
	bit               prime_map [MAP_DEPTH];
	bit               map_ready    = 1'b0;
	int unsigned      sieved_limit = 0;
	logic [CFG_W-1:0] limit_reg    = SIEVE_LIMIT_RST;

	partition_result_t expected_results [$];

	// Bookkeeping
	bit          steady      = 1'b0;
	int unsigned fail_count  = 0;
	int unsigned n_builds    = 0;
	int unsigned n_counts    = 0;
	int unsigned n_err_sts   = 0;
	int unsigned n_checked   = 0;
	int unsigned cycle_count = 0;

	goldbach_partition_counter_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still pending",
				cycle_count, expected_results.size());
			$display("** goldbach_partition_counter_core: FAILED **");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		fail_count++;
		$display("[%0t] MISMATCH: %s", $realtime, what);
	endtask

	// ------------------------------------------------------------------------
	// Predictor: odd-only sieve, index n/2 holds odd n
	// ------------------------------------------------------------------------
	function automatic logic [CNT_W-1:0] sieve_build();
		int unsigned lim, top, i, j, tally;
		lim = limit_reg;
		if (lim < MIN_LIMIT) lim = MIN_LIMIT;
		if (lim > DEF_MAX_LIMIT) lim = DEF_MAX_LIMIT;
		top = (lim - 1) / 2;
		// index 0 is 1, never prime
		for (i = 0; i < MAP_DEPTH; i++)
			prime_map[i] = (i >= 1 && i <= top);
		for (i = 3; i * i <= lim; i += 2) begin
			if (prime_map[i >> 1]) begin
				for (j = i * i; j <= lim; j += 2 * i)
					prime_map[j >> 1] = 1'b0;
			end
		end
		// 2 counts too
		tally = 1;
		for (i = 1; i <= top; i++)
			tally += prime_map[i];
		map_ready    = 1'b1;
		sieved_limit = lim;
		return (tally > COUNT_MAX) ? COUNT_MAX : CNT_W'(tally);
	endfunction

	function automatic bit prime_check(input int unsigned n);
		if (n < 2) return 1'b0;
		if (n == 2) return 1'b1;
		if (n % 2 == 0) return 1'b0;
		if ((n >> 1) >= MAP_DEPTH) return 1'b0;
		return prime_map[n >> 1];
	endfunction

	function automatic logic [CNT_W-1:0] partition_count(input int unsigned x);
		int unsigned p, tally;
		tally = 0;
		if (x <= 2 || x % 2 != 0) return '0;
		if (prime_check(x - 2)) tally++;
		for (p = 3; p <= x / 2; p += 2) begin
			if (prime_check(p) && prime_check(x - p)) tally++;
		end
		return (tally > COUNT_MAX) ? COUNT_MAX : CNT_W'(tally);
	endfunction

	function automatic partition_result_t predict_result(input logic cmd,
			input logic [NUM_W-1:0] number);
		partition_result_t r;
		r.count  = '0;
		r.status = STS_OK;
		if (cmd == CMD_BUILD)
			r.count = sieve_build();
		else if (!map_ready)
			r.status = STS_NOT_BUILT;
		else if (number > sieved_limit)
			r.status = STS_ABOVE;
		else
			r.count = partition_count(number);
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	// One APB transfer to the sieve_limit register; psel drops before the task returns
	task automatic apb_access(input logic write, input logic [APB_W-1:0] wdata);
		logic [APB_W-1:0] got;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write;
		paddr   <= SIEVE_LIMIT_ADDR;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		got = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (write)
			limit_reg = wdata[CFG_W-1:0];
		else if (got !== APB_W'(limit_reg))
			report_mismatch($sformatf("sieve_limit read 0x%0h, expected 0x%0h",
				got, limit_reg));
		@(posedge clk);
	endtask

	// Present one item after a random gap; predict it once transferred
	task automatic send_item(input logic cmd, input logic [NUM_W-1:0] number);
		int unsigned gap;
		partition_result_t r;
		gap = steady ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= DATA_W'(number);
		@(posedge clk);
		while (!(s_tvalid && s_tready)) @(posedge clk);
		r = predict_result(cmd, number);
		expected_results.push_back(r);
		if (cmd == CMD_BUILD) n_builds++;
		else n_counts++;
		if (r.status != STS_OK) n_err_sts++;
	endtask

	// Stop sending and wait until every prediction has been matched
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Result checker with random back-pressure
	// ------------------------------------------------------------------------
	initial begin : result_sink
		int unsigned stall;
		partition_result_t want;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = steady ? 0 : $urandom_range(0, MAX_GAP);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!(m_tvalid && m_tready)) @(posedge clk);
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending, tdata 0x%0h",
					m_tdata));
			end else begin
				want = expected_results.pop_front();
				n_checked++;
				if (m_tdata[CNT_W-1:0] !== want.count)
					report_mismatch($sformatf("count %0d, expected %0d",
						m_tdata[CNT_W-1:0], want.count));
				if (m_tdata[CNT_W+STS_W-1:CNT_W] !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						m_tdata[CNT_W+STS_W-1:CNT_W], want.status));
			end
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	// Register reset value and counts before any build
	task automatic test_reset_state();
		apb_access(1'b0, '0);
		send_item(CMD_COUNT, '0);
		send_item(CMD_COUNT, NUM_W'(4));
		send_item(CMD_COUNT, NUM_W'(100000));
		send_item(CMD_COUNT, NUM_W'(NUM_MAX));
		drain_results();
	endtask

	// Smallest sieve, tiny and odd numbers, limits clamped up to the minimum
	task automatic test_min_limit();
		apb_access(1'b1, APB_W'(MIN_LIMIT));
		apb_access(1'b0, '0);
		send_item(CMD_BUILD, '0);
		send_item(CMD_COUNT, NUM_W'(4));
		send_item(CMD_COUNT, NUM_W'(2));
		send_item(CMD_COUNT, NUM_W'(0));
		send_item(CMD_COUNT, NUM_W'(1));
		send_item(CMD_COUNT, NUM_W'(3));
		send_item(CMD_COUNT, NUM_W'(5));
		send_item(CMD_COUNT, NUM_W'(6));
		drain_results();
		apb_access(1'b1, '0);
		apb_access(1'b0, '0);
		send_item(CMD_BUILD, NUM_W'(NUM_MAX));
		send_item(CMD_COUNT, NUM_W'(4));
		drain_results();
	endtask

	// Limit above the maximum is clamped; largest numbers around it
	task automatic test_max_limit();
		apb_access(1'b1, '1);
		apb_access(1'b0, '0);
		send_item(CMD_BUILD, NUM_W'(NUM_MAX));
		send_item(CMD_COUNT, NUM_W'(DEF_MAX_LIMIT));
		send_item(CMD_COUNT, NUM_W'(DEF_MAX_LIMIT - 2));
		send_item(CMD_COUNT, NUM_W'(DEF_MAX_LIMIT - 1));
		send_item(CMD_COUNT, NUM_W'(NUM_MAX));
		send_item(CMD_COUNT, NUM_W'(DEF_MAX_LIMIT + 2));
		send_item(CMD_COUNT, NUM_W'(100));
		send_item(CMD_COUNT, NUM_W'(98));
		drain_results();
	endtask

	// Random limits, mostly small; counts, rebuilds and error cases mixed
	task automatic test_random_phases();
		int unsigned lim, span, pick;
		logic [APB_W-1:0] wdata;
		bit wide;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			wide   = (ph == WIDE_PHASE);
			steady = (ph % 3 == 2);
			lim    = wide ? $urandom_range(20000, NUM_MAX) : $urandom_range(0, 6000);
			wdata  = $urandom;
			wdata[CFG_W-1:0] = lim[CFG_W-1:0];
			apb_access(1'b1, wdata);
			apb_access(1'b0, '0);
			send_item(CMD_BUILD, NUM_W'($urandom));
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				pick = (wide && i < 2) ? 0 : $urandom_range(0, 99);
				// wide sieve: keep most counts short, two span the whole range
				span = (wide && i >= 2 && sieved_limit > WIDE_SPAN) ? WIDE_SPAN
					: sieved_limit;
				if (!wide && pick < 8)
					send_item(CMD_BUILD, NUM_W'($urandom));
				else if (pick < 70)
					send_item(CMD_COUNT, NUM_W'(2 * $urandom_range(0, span / 2)));
				else if (pick < 80)
					send_item(CMD_COUNT, NUM_W'(2 * $urandom_range(0, (span - 1) / 2) + 1));
				else if (pick < 90 || wide)
					send_item(CMD_COUNT, NUM_W'($urandom_range(sieved_limit + 1, NUM_MAX)));
				else
					send_item(CMD_COUNT, NUM_W'($urandom));
			end
			drain_results();
			steady = 1'b0;
		end
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= CMD_BUILD;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_min_limit();
		test_max_limit();
		test_random_phases();

		repeat (END_CYCLES) @(posedge clk);

		$display("Sent %0d sieve builds and %0d partition counts, %0d with an error status.",
			n_builds, n_counts, n_err_sts);
		$display("Checked %0d results, %0d mismatches.", n_checked, fail_count);
		if (fail_count == 0)
			$display("** goldbach_partition_counter_core: PASSED **");
		else
			$display("** goldbach_partition_counter_core: FAILED **");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/gpc_pkg.sv
hw/rtl/gpc_ram.sv
hw/rtl/goldbach_partition_counter_core.sv
verif/goldbach_partition_counter_core_tb.sv
